// ===== hdl/sia_pkg.sv =====
// ----------------------------------------------------------------------------
// sia_pkg
// Shared types and constants for the scalar imm16 ALU: field widths, action
// codes and the structs passed between the ALU, register file and top level.
// ----------------------------------------------------------------------------
package sia_pkg;

   localparam int SIA_NUM_REGS = 128;
   localparam int ACTION_W     = 2;
   localparam int DST_W        = 7;
   localparam int IMM_W        = 16;
   localparam int DATA_W       = 32;
   localparam int SIGN_BIT     = DATA_W - 1;
   localparam int PROD_W       = DATA_W + IMM_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_MOVK = 2'd0,
      ACT_ADDK = 2'd1,
      ACT_MULK = 2'd2,
      ACT_SET  = 2'd3
   } sia_action_type;

   // register file write port
   typedef struct packed {
      logic              en;
      logic [DST_W-1:0]  idx;
      logic [DATA_W-1:0] data;
   } sia_wr_type;

   // ALU outcome for one item
   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              cond_written;
      logic              cond_new;
   } sia_exec_type;

endpackage

// ===== hdl/sia_req_if.sv =====
// ----------------------------------------------------------------------------
// sia_req_if
// Valid/ready channel carrying one instruction item into the ALU.
// ----------------------------------------------------------------------------
interface sia_req_if
   import sia_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [DST_W-1:0]    dst_index;
   logic [IMM_W-1:0]    imm16;
   logic [DATA_W-1:0]   set_value;

   modport source (output valid, output action, output dst_index, output imm16,
                   output set_value, input ready);
   modport sink   (input valid, input action, input dst_index, input imm16,
                   input set_value, output ready);
endinterface

// ===== hdl/sia_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sia_rsp_if
// Valid/ready channel carrying one result item out of the ALU.
// ----------------------------------------------------------------------------
interface sia_rsp_if
   import sia_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DST_W-1:0]  out_index;
   logic [DATA_W-1:0] out_value;
   logic              cond_written;
   logic              cond_value;

   modport source (output valid, output out_index, output out_value,
                   output cond_written, output cond_value, input ready);
   modport sink   (input valid, input out_index, input out_value,
                   input cond_written, input cond_value, output ready);
endinterface

// ===== hdl/scalar_imm16_alu_top.sv =====
// The destination register is read at accept, then the item executes into the
// output register.
// Throughput: one item per cycle when the result side is ready; back-to-back
// writes to the same register are forwarded from the last write, so there are
// no interlock bubbles. Reset clears all register valid bits and the condition
// bit with no clearing sweep; items are taken as soon as reset is released.
// ----------------------------------------------------------------------------
// scalar_imm16_alu_top
// Scalar imm16 ALU: reads the destination register, executes the action,
// writes back and emits one result item per instruction item.
// ----------------------------------------------------------------------------
module scalar_imm16_alu_top
   import sia_pkg::*;
#(
   parameter int NUM_SCALAR_REGS = SIA_NUM_REGS
) (
   input logic        clock,
   input logic        reset,
   sia_req_if.sink    req_ch,
   sia_rsp_if.source  rsp_ch
);

   // execute stage
   logic              s1_valid_ff, s1_valid_in;
   sia_action_type    s1_action_ff;
   logic [DST_W-1:0]  s1_idx_ff;
   logic [IMM_W-1:0]  s1_imm_ff;
   logic [DATA_W-1:0] s1_set_ff;

   // last write, for forwarding into the execute stage
   logic              wb_valid_ff, wb_valid_in;
   logic [DST_W-1:0]  wb_idx_ff;
   logic [DATA_W-1:0] wb_data_ff;

   logic              cond_ff, cond_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DST_W-1:0]  rsp_idx_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic              rsp_cwr_ff;
   logic              rsp_cond_ff;

   logic              req_acc;
   logic              s1_adv;
   logic              s1_in_range;
   logic              fwd_hit;
   logic [DATA_W-1:0] rd_data;
   logic              rd_hit;
   logic [DATA_W-1:0] cur;
   sia_exec_type      ex;
   sia_wr_type        wr;

   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready   = !s1_valid_ff || s1_adv;
   assign req_acc        = req_ch.valid && req_ch.ready;
   assign s1_in_range    = int'(s1_idx_ff) < NUM_SCALAR_REGS;
   assign fwd_hit        = wb_valid_ff && (wb_idx_ff == s1_idx_ff);

   always_comb begin
      if (!s1_in_range) begin
         cur = '0;
      end else if (fwd_hit) begin
         cur = wb_data_ff;
      end else if (rd_hit) begin
         cur = rd_data;
      end else begin
         cur = '0;
      end
   end

   sia_regfile #(
      .NUM_REGS (NUM_SCALAR_REGS)
   ) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_acc),
      .rd_idx  (req_ch.dst_index),
      .wr      (wr),
      .rd_data (rd_data),
      .rd_hit  (rd_hit)
   );

   sia_exec u_exec (
      .action    (s1_action_ff),
      .cur       (cur),
      .imm16     (s1_imm_ff),
      .set_value (s1_set_ff),
      .cond_old  (cond_ff),
      .ex        (ex)
   );

   assign wr.en   = s1_adv && s1_in_range;
   assign wr.idx  = s1_idx_ff;
   assign wr.data = ex.result;

   assign s1_valid_in  = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign wb_valid_in  = s1_adv ? s1_in_range : wb_valid_ff;
   assign cond_in      = s1_adv ? ex.cond_new : cond_ff;
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
         cond_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         wb_valid_ff  <= wb_valid_in;
         cond_ff      <= cond_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_action_ff <= sia_action_type'(req_ch.action);
         s1_idx_ff    <= req_ch.dst_index;
         s1_imm_ff    <= req_ch.imm16;
         s1_set_ff    <= req_ch.set_value;
      end
      if (s1_adv) begin
         wb_idx_ff    <= s1_idx_ff;
         wb_data_ff   <= ex.result;
         rsp_idx_ff   <= s1_idx_ff;
         rsp_value_ff <= ex.result;
         rsp_cwr_ff   <= ex.cond_written;
         rsp_cond_ff  <= ex.cond_new;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_index    = rsp_idx_ff;
   assign rsp_ch.out_value    = rsp_value_ff;
   assign rsp_ch.cond_written = rsp_cwr_ff;
   assign rsp_ch.cond_value   = rsp_cond_ff;

   // stalled execute stage keeps its item
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_idx_ff) && $stable(s1_action_ff))
      else $error("execute stage lost a stalled item");

   a_cwr_action: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_ch.cond_written ==
                 ($past(s1_action_ff) == ACT_ADDK || $past(s1_action_ff) == ACT_MULK))
      else $error("cond_written does not match action");

   a_cond_keep: assert property (@(posedge clock) disable iff (reset)
      s1_adv && (s1_action_ff == ACT_MOVK || s1_action_ff == ACT_SET) |=> $stable(cond_ff))
      else $error("condition bit changed by movk or set");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> int'(wr.idx) < NUM_SCALAR_REGS)
      else $error("register write beyond file depth");

endmodule

// ===== hdl/sia_regfile.sv =====
// ----------------------------------------------------------------------------
// sia_regfile
// Scalar register file: synchronous memory, one write and one registered read
// per cycle (read-first). Per-entry valid bits flag unwritten entries on rd_hit.
// ----------------------------------------------------------------------------
module sia_regfile
   import sia_pkg::*;
#(
   parameter int NUM_REGS = SIA_NUM_REGS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [DST_W-1:0]  rd_idx,
   input  sia_wr_type        wr,
   output logic [DATA_W-1:0] rd_data,
   output logic              rd_hit
);

   localparam int IDX_W = $clog2(NUM_REGS);

   logic [DATA_W-1:0] regs_ff [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_ff[wr.idx[IDX_W-1:0]] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= regs_ff[rd_idx[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.idx[IDX_W-1:0]] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= valid_ff[rd_idx[IDX_W-1:0]];
         end
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_hit  = rd_hit_ff;

endmodule

// ===== hdl/sia_exec.sv =====
// ----------------------------------------------------------------------------
// sia_exec
// Immediate ALU: movk, addk and mulk with signed overflow into the condition
// bit, plus a direct register set.
// ----------------------------------------------------------------------------
module sia_exec
   import sia_pkg::*;
(
   input  sia_action_type    action,
   input  logic [DATA_W-1:0] cur,
   input  logic [IMM_W-1:0]  imm16,
   input  logic [DATA_W-1:0] set_value,
   input  logic              cond_old,
   output sia_exec_type      ex
);

   logic [DATA_W-1:0] imm_ext;
   logic [DATA_W-1:0] sum;
   logic              add_ovf;
   logic [PROD_W-1:0] prod;
   logic              mul_ovf;

   assign imm_ext = {{(DATA_W-IMM_W){imm16[IMM_W-1]}}, imm16};
   assign sum     = cur + imm_ext;
   assign add_ovf = ~(cur[SIGN_BIT] ^ imm_ext[SIGN_BIT]) & (cur[SIGN_BIT] ^ sum[SIGN_BIT]);
   assign prod    = PROD_W'($signed(cur) * $signed(imm16));
   // product fits when every bit above the low word repeats its sign bit
   assign mul_ovf = !((&prod[PROD_W-1:SIGN_BIT]) || !(|prod[PROD_W-1:SIGN_BIT]));

   always_comb begin
      ex.result       = imm_ext;
      ex.cond_written = 1'b0;
      ex.cond_new     = cond_old;
      unique case (action)
         ACT_MOVK: begin
            ex.result = imm_ext;
         end
         ACT_ADDK: begin
            ex.result       = sum;
            ex.cond_written = 1'b1;
            ex.cond_new     = add_ovf;
         end
         ACT_MULK: begin
            ex.result       = prod[DATA_W-1:0];
            ex.cond_written = 1'b1;
            ex.cond_new     = mul_ovf;
         end
         ACT_SET: begin
            ex.result = set_value;
         end
         default: begin
            ex.result = imm_ext;
         end
      endcase
   end

endmodule

// ===== verif/scalar_imm16_alu_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_imm16_alu_top_tb
// Self-checking bench for the scalar imm16 ALU. A queue of instruction items
// (directed corner cases, then biased random ones) feeds a clocked driver;
// a shadow register file and condition bit predict each result item, and a
// clocked monitor compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module scalar_imm16_alu_top_tb;
   import sia_pkg::*;

   localparam int REG_COUNT    = SIA_NUM_REGS;
   localparam int RANDOM_ITEMS = 1500;
   localparam int IDLE_PCT     = 37;
   localparam int CALM_LO      = 1000;
   localparam int CALM_HI      = 1250;
   localparam int HOLD_AT      = 400;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      sia_action_type    action;
      logic [DST_W-1:0]  dst_index;
      logic [IMM_W-1:0]  imm16;
      logic [DATA_W-1:0] set_value;
   } instr_type;

   typedef struct packed {
      logic [DST_W-1:0]  out_index;
      logic [DATA_W-1:0] out_value;
      logic              cond_written;
      logic              cond_value;
   } reg_write_type;

   logic clock;
   logic reset;

   sia_req_if req_ch ();
   sia_rsp_if rsp_ch ();

   scalar_imm16_alu_top #(
      .NUM_SCALAR_REGS (REG_COUNT)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   instr_type         pending_instrs[$];
   reg_write_type     expected_writes[$];
   logic [DATA_W-1:0] shadow_regs[REG_COUNT];
   logic              shadow_cond;

   int   items_queued   = 0;
   int   items_accepted = 0;
   int   mismatch_count = 0;
   int   hold_left      = 0;
   bit   hold_done      = 1'b0;
   bit   req_taken      = 1'b0;
   instr_type     next_instr;
   instr_type     taken_instr;
   reg_write_type got_write;
   reg_write_type want_write;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // computes the register write for one item and updates the shadow state
   function automatic reg_write_type exec_imm16(input instr_type it);
      reg_write_type     w;
      logic [DATA_W-1:0] imm;
      logic [DATA_W-1:0] cur;
      logic [DATA_W-1:0] res;
      logic [2*DATA_W-1:0] prod;
      logic              in_range;
      imm      = {{(DATA_W-IMM_W){it.imm16[IMM_W-1]}}, it.imm16};
      in_range = int'(it.dst_index) < REG_COUNT;
      cur      = in_range ? shadow_regs[it.dst_index] : '0;
      w.cond_written = 1'b0;
      case (it.action)
         ACT_MOVK: begin
            res = imm;
         end
         ACT_ADDK: begin
            res = cur + imm;
            shadow_cond = ~(cur[SIGN_BIT] ^ imm[SIGN_BIT]) & (cur[SIGN_BIT] ^ res[SIGN_BIT]);
            w.cond_written = 1'b1;
         end
         ACT_MULK: begin
            prod = $signed({{DATA_W{cur[SIGN_BIT]}}, cur}) *
                   $signed({{DATA_W{imm[SIGN_BIT]}}, imm});
            res = prod[DATA_W-1:0];
            // overflow either way: full product must equal its sign-extended low word
            shadow_cond = (prod != {{DATA_W{res[SIGN_BIT]}}, res});
            w.cond_written = 1'b1;
         end
         default: begin
            res = it.set_value;
         end
      endcase
      if (in_range)
         shadow_regs[it.dst_index] = res;
      w.out_index  = it.dst_index;
      w.out_value  = res;
      w.cond_value = shadow_cond;
      return w;
   endfunction

   function automatic int idle_pct();
      return (items_accepted >= CALM_LO && items_accepted < CALM_HI) ? 0 : IDLE_PCT;
   endfunction

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic push_instr(input sia_action_type act, input logic [DST_W-1:0] dst,
                             input logic [IMM_W-1:0] imm, input logic [DATA_W-1:0] setv);
      instr_type it;
      it.action    = act;
      it.dst_index = dst;
      it.imm16     = imm;
      it.set_value = setv;
      pending_instrs.push_back(it);
      items_queued++;
   endtask

   task automatic push_random_instr();
      logic [IMM_W-1:0]  imm_picks[7]  = '{16'h0000, 16'h0001, 16'h0002, 16'h7FFF,
                                           16'h8000, 16'hFFFE, 16'hFFFF};
      logic [DATA_W-1:0] val_picks[6]  = '{32'h0000_0000, 32'h0000_0001, 32'h4000_0000,
                                           32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
      logic [DST_W-1:0]  dst;
      logic [IMM_W-1:0]  imm;
      logic [DATA_W-1:0] setv;
      int                pick;
      pick = $urandom_range(0, 99);
      // mostly a few hot registers, so values build up and writes land back to back
      if (pick < 55)
         dst = DST_W'($urandom_range(0, 7));
      else if (pick < 65)
         dst = (pick < 60) ? '0 : DST_W'(REG_COUNT - 1);
      else
         dst = DST_W'($urandom);
      imm  = ($urandom_range(0, 99) < 25) ? imm_picks[$urandom_range(0, 6)] : IMM_W'($urandom);
      setv = ($urandom_range(0, 99) < 30) ? val_picks[$urandom_range(0, 5)] : $urandom;
      push_instr(sia_action_type'($urandom_range(0, 3)), dst, imm, setv);
   endtask

   // driver: presents items at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         req_taken = 1'b0;
         if (pending_instrs.size() != 0 &&
             $urandom_range(0, 99) >= ((hold_left != 0) ? 0 : idle_pct())) begin
            next_instr          = pending_instrs.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.action      <= next_instr.action;
            req_ch.dst_index   <= next_instr.dst_index;
            req_ch.imm16       <= next_instr.imm16;
            req_ch.set_value   <= next_instr.set_value;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result side ready, with one long hold-off so the block backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && items_accepted >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct());
      end
   end

   // monitor: predict on accepted items, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            taken_instr.action    = sia_action_type'(req_ch.action);
            taken_instr.dst_index = req_ch.dst_index;
            taken_instr.imm16     = req_ch.imm16;
            taken_instr.set_value = req_ch.set_value;
            expected_writes.push_back(exec_imm16(taken_instr));
            items_accepted++;
            req_taken = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_write.out_index    = rsp_ch.out_index;
            got_write.out_value    = rsp_ch.out_value;
            got_write.cond_written = rsp_ch.cond_written;
            got_write.cond_value   = rsp_ch.cond_value;
            if (expected_writes.size() == 0) begin
               $display("%0t: unexpected result item, expected none actual idx=%0d value=%h",
                        $time, got_write.out_index, got_write.out_value);
               mismatch_count++;
            end else begin
               want_write = expected_writes.pop_front();
               check_field("out_index", DATA_W'(want_write.out_index),
                           DATA_W'(got_write.out_index));
               check_field("out_value", want_write.out_value, got_write.out_value);
               check_field("cond_written", DATA_W'(want_write.cond_written),
                           DATA_W'(got_write.cond_written));
               check_field("cond_value", DATA_W'(want_write.cond_value),
                           DATA_W'(got_write.cond_value));
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.action    = ACT_MOVK;
      req_ch.dst_index = '0;
      req_ch.imm16     = '0;
      req_ch.set_value = '0;
      rsp_ch.ready     = 1'b0;
      for (int i = 0; i < REG_COUNT; i++)
         shadow_regs[i] = '0;
      shadow_cond = 1'b0;

      // directed corner cases
      push_instr(ACT_MOVK, 7'd0,   16'h0000, 32'h0000_0000);
      push_instr(ACT_MOVK, 7'd127, 16'hFFFF, 32'h0000_0000);
      push_instr(ACT_MOVK, 7'd1,   16'h7FFF, 32'h0000_0000);
      push_instr(ACT_MOVK, 7'd2,   16'h8000, 32'h0000_0000);
      push_instr(ACT_SET,  7'd3,   16'h0000, 32'hFFFF_FFFF);
      push_instr(ACT_ADDK, 7'd3,   16'h0001, 32'h0000_0000);
      push_instr(ACT_SET,  7'd4,   16'hFFFF, 32'h7FFF_FFFF);
      push_instr(ACT_ADDK, 7'd4,   16'h0001, 32'h0000_0000);  // positive overflow
      push_instr(ACT_MOVK, 7'd4,   16'h1234, 32'hFFFF_FFFF);  // cond held, set_value ignored
      push_instr(ACT_SET,  7'd5,   16'h0000, 32'h8000_0000);
      push_instr(ACT_ADDK, 7'd5,   16'hFFFF, 32'h0000_0000);  // negative overflow
      push_instr(ACT_ADDK, 7'd5,   16'h0000, 32'h0000_0000);
      push_instr(ACT_SET,  7'd6,   16'h0000, 32'h4000_0000);
      push_instr(ACT_MULK, 7'd6,   16'h0002, 32'h0000_0000);
      push_instr(ACT_SET,  7'd7,   16'h0000, 32'h4000_0000);
      push_instr(ACT_MULK, 7'd7,   16'hFFFE, 32'h0000_0000);  // exactly min int, no overflow
      push_instr(ACT_SET,  7'd8,   16'h0000, 32'h7FFF_FFFF);
      push_instr(ACT_MULK, 7'd8,   16'h8000, 32'h0000_0000);  // negative product overflow
      push_instr(ACT_SET,  7'd9,   16'h0000, 32'h8000_0000);
      push_instr(ACT_MULK, 7'd9,   16'hFFFF, 32'h0000_0000);
      push_instr(ACT_MULK, 7'd1,   16'h7FFF, 32'h0000_0000);
      push_instr(ACT_MULK, 7'd1,   16'h7FFF, 32'h0000_0000);
      push_instr(ACT_ADDK, 7'd1,   16'h8000, 32'h0000_0000);
      push_instr(ACT_SET,  7'd127, 16'hFFFF, 32'h0000_0000);
      push_instr(ACT_ADDK, 7'd127, 16'h7FFF, 32'hFFFF_FFFF);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // let the directed items drain completely before the random part
      while (items_accepted < items_queued) @(posedge clock);
      while (expected_writes.size() != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_ITEMS; n++)
         push_random_instr();

      while (items_accepted < items_queued) @(posedge clock);
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d items still expected", $time, expected_writes.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
